[rtl/escape_time_fractal_unit_macros.svh]
// Assertion macros used by the escape-time fractal RTL.
`ifndef ESCAPE_TIME_FRACTAL_UNIT_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define ETF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ETF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ETF_ASSERT(lbl, clk, rst_n, prop, msg)
`define ETF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/etf_pkg.sv]
package etf_pkg;

    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 768;
    localparam int FRAC_BITS    = 27;

    localparam int PIX_W      = 10;
    localparam int ITER_W     = 16;
    localparam int FIX_W      = 32;
    localparam int ZOOM_W     = 31;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int PROD_W     = 2 * FIX_W;
    // Shifted squares plus headroom for the sums of one iteration step.
    localparam int WIDE_W     = PROD_W - FRAC_BITS + 3;
    // Frame sizes go up to 4096.
    localparam int FRAME_W    = 13;
    localparam int NUM_W      = FRAME_W + PIX_W;

    // The remainder term of the mapping is divided by the frame size through a
    // rounded-up reciprocal; the shift keeps the quotient exact for any NUM_W-bit
    // numerator and any frame size up to 4096.
    localparam int DIV_SH     = NUM_W + FRAME_W;
    localparam int DIV_PROD_W = NUM_W + DIV_SH;

    localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd2;

    localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd100;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET       = ZOOM_W'(longint'(1) << FRAC_BITS);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE,
        CFG_ITER_LIMIT,
        CFG_ZOOM,
        CFG_OFFSET_RE,
        CFG_OFFSET_IM,
        CFG_JULIA_RE,
        CFG_JULIA_IM
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_MANDEL,
        KIND_JULIA,
        KIND_SHIP
    } kind_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [ITER_W-1:0]        iter_limit;
        logic [ZOOM_W-1:0]        zoom;
        logic signed [FIX_W-1:0]  offset_re;
        logic signed [FIX_W-1:0]  offset_im;
        logic signed [FIX_W-1:0]  julia_re;
        logic signed [FIX_W-1:0]  julia_im;
    } cfg_t;

    typedef struct packed {
        kind_t                    kind;
        logic [PIX_W-1:0]         px;
        logic [PIX_W-1:0]         py;
        logic signed [FIX_W-1:0]  zr;
        logic signed [FIX_W-1:0]  zi;
        logic signed [FIX_W-1:0]  cr;
        logic signed [FIX_W-1:0]  ci;
    } job_t;

    // Converts hundredths to fixed point, rounding the magnitude to nearest.
    function automatic longint to_fixed(input int hundredths);
        longint mag;
        longint unit;
        longint q;
        mag  = (hundredths < 0) ? -longint'(hundredths) : longint'(hundredths);
        unit = longint'(1) << FRAC_BITS;
        q    = mag * (unit / 100) + (mag * (unit % 100) + 50) / 100;
        return (hundredths < 0) ? -q : q;
    endfunction

    localparam longint RECIP_X = ((longint'(1) << DIV_SH) + FRAME_WIDTH - 1) / FRAME_WIDTH;
    localparam longint RECIP_Y = ((longint'(1) << DIV_SH) + FRAME_HEIGHT - 1) / FRAME_HEIGHT;

    // Window bounds of each mode, split into per-pixel quotient and remainder.
    localparam longint MB_RE_LO   = to_fixed(-200);
    localparam longint MB_RE_SPAN = to_fixed(47) - MB_RE_LO;
    localparam longint MB_RE_QUOT = MB_RE_SPAN / FRAME_WIDTH;
    localparam longint MB_RE_REM  = MB_RE_SPAN % FRAME_WIDTH;
    localparam longint MB_IM_LO   = to_fixed(-112);
    localparam longint MB_IM_SPAN = to_fixed(112) - MB_IM_LO;
    localparam longint MB_IM_QUOT = MB_IM_SPAN / FRAME_HEIGHT;
    localparam longint MB_IM_REM  = MB_IM_SPAN % FRAME_HEIGHT;

    localparam longint JU_LO      = to_fixed(-200);
    localparam longint JU_SPAN    = to_fixed(200) - JU_LO;
    localparam longint JU_RE_QUOT = JU_SPAN / FRAME_WIDTH;
    localparam longint JU_RE_REM  = JU_SPAN % FRAME_WIDTH;
    localparam longint JU_IM_QUOT = JU_SPAN / FRAME_HEIGHT;
    localparam longint JU_IM_REM  = JU_SPAN % FRAME_HEIGHT;

    localparam longint BS_LO      = to_fixed(-250);
    localparam longint BS_SPAN    = to_fixed(150) - BS_LO;
    localparam longint BS_RE_QUOT = BS_SPAN / FRAME_WIDTH;
    localparam longint BS_RE_REM  = BS_SPAN % FRAME_WIDTH;
    localparam longint BS_IM_QUOT = BS_SPAN / FRAME_HEIGHT;
    localparam longint BS_IM_REM  = BS_SPAN % FRAME_HEIGHT;

    localparam longint FOUR = longint'(4) << FRAC_BITS;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((longint'(1) << (FIX_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [PROD_W-1:0] v);
        logic signed [FIX_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(FIX_W - 1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(FIX_W - 1){1'b0}}};
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/etf_front.sv]
`include "escape_time_fractal_unit_macros.svh"

module etf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  etf_pkg::cfg_t                   cfg_i,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [etf_pkg::PIX_W-1:0]       s_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]       s_pixel_y,
    input  logic                            full_i,
    output logic                            push_o,
    output etf_pkg::job_t                   job_o
);

    localparam int PIX_W      = etf_pkg::PIX_W;
    localparam int FIX_W      = etf_pkg::FIX_W;
    localparam int PROD_W     = etf_pkg::PROD_W;
    localparam int NUM_W      = etf_pkg::NUM_W;
    localparam int FRAME_W    = etf_pkg::FRAME_W;
    localparam int DIV_PROD_W = etf_pkg::DIV_PROD_W;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DIV,
        F_MUL,
        F_ADD,
        F_PUSH
    } fstate_t;

    fstate_t                   state_reg;
    etf_pkg::kind_t            kind_reg;
    logic [PIX_W-1:0]          px_reg;
    logic [PIX_W-1:0]          py_reg;
    logic signed [PROD_W-1:0]  base_x_reg;
    logic signed [PROD_W-1:0]  base_y_reg;
    logic [NUM_W-1:0]          num_x_reg;
    logic [NUM_W-1:0]          num_y_reg;
    logic [PIX_W-1:0]          quo_x_reg;
    logic [PIX_W-1:0]          quo_y_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [FIX_W-1:0]   coord_x_reg;
    logic signed [FIX_W-1:0]   coord_y_reg;

    etf_pkg::kind_t            kind_sel;
    logic signed [FIX_W-1:0]   lo_x;
    logic signed [FIX_W-1:0]   lo_y;
    logic signed [FIX_W-1:0]   quot_x;
    logic signed [FIX_W-1:0]   quot_y;
    logic [FRAME_W-1:0]        rem_x;
    logic [FRAME_W-1:0]        rem_y;
    logic [DIV_PROD_W-1:0]     quo_x_full;
    logic [DIV_PROD_W-1:0]     quo_y_full;
    logic signed [FIX_W-1:0]   m_x;
    logic signed [FIX_W-1:0]   m_y;
    logic signed [FIX_W-1:0]   t_x;
    logic signed [FIX_W-1:0]   t_y;

    always_comb begin
        case (cfg_i.mode)
            etf_pkg::MODE_JULIA: begin
                kind_sel = etf_pkg::KIND_JULIA;
                lo_x     = FIX_W'(etf_pkg::JU_LO);
                lo_y     = FIX_W'(etf_pkg::JU_LO);
                quot_x   = FIX_W'(etf_pkg::JU_RE_QUOT);
                quot_y   = FIX_W'(etf_pkg::JU_IM_QUOT);
                rem_x    = FRAME_W'(etf_pkg::JU_RE_REM);
                rem_y    = FRAME_W'(etf_pkg::JU_IM_REM);
            end
            etf_pkg::MODE_SHIP: begin
                kind_sel = etf_pkg::KIND_SHIP;
                lo_x     = FIX_W'(etf_pkg::BS_LO);
                lo_y     = FIX_W'(etf_pkg::BS_LO);
                quot_x   = FIX_W'(etf_pkg::BS_RE_QUOT);
                quot_y   = FIX_W'(etf_pkg::BS_IM_QUOT);
                rem_x    = FRAME_W'(etf_pkg::BS_RE_REM);
                rem_y    = FRAME_W'(etf_pkg::BS_IM_REM);
            end
            default: begin
                // The unused mode code falls back to Mandelbrot.
                kind_sel = etf_pkg::KIND_MANDEL;
                lo_x     = FIX_W'(etf_pkg::MB_RE_LO);
                lo_y     = FIX_W'(etf_pkg::MB_IM_LO);
                quot_x   = FIX_W'(etf_pkg::MB_RE_QUOT);
                quot_y   = FIX_W'(etf_pkg::MB_IM_QUOT);
                rem_x    = FRAME_W'(etf_pkg::MB_RE_REM);
                rem_y    = FRAME_W'(etf_pkg::MB_IM_REM);
            end
        endcase
    end

    // The quotient of the remainder term is below the pixel coordinate, so it
    // fits the pixel width above the reciprocal shift.
    assign quo_x_full = DIV_PROD_W'(num_x_reg) * DIV_PROD_W'(etf_pkg::RECIP_X);
    assign quo_y_full = DIV_PROD_W'(num_y_reg) * DIV_PROD_W'(etf_pkg::RECIP_Y);

    assign m_x = etf_pkg::sat_fix(base_x_reg + PROD_W'($signed({1'b0, quo_x_reg})));
    assign m_y = etf_pkg::sat_fix(base_y_reg + PROD_W'($signed({1'b0, quo_y_reg})));

    assign t_x = etf_pkg::sat_fix(prod_x_reg >>> etf_pkg::FRAC_BITS);
    assign t_y = etf_pkg::sat_fix(prod_y_reg >>> etf_pkg::FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        kind_reg   <= kind_sel;
                        px_reg     <= s_pixel_x;
                        py_reg     <= s_pixel_y;
                        base_x_reg <= PROD_W'(lo_x)
                                      + PROD_W'(quot_x) * PROD_W'($signed({1'b0, s_pixel_x}));
                        base_y_reg <= PROD_W'(lo_y)
                                      + PROD_W'(quot_y) * PROD_W'($signed({1'b0, s_pixel_y}));
                        num_x_reg  <= NUM_W'(rem_x) * NUM_W'(s_pixel_x);
                        num_y_reg  <= NUM_W'(rem_y) * NUM_W'(s_pixel_y);
                        state_reg  <= F_DIV;
                    end
                end
                F_DIV: begin
                    quo_x_reg <= quo_x_full[etf_pkg::DIV_SH +: PIX_W];
                    quo_y_reg <= quo_y_full[etf_pkg::DIV_SH +: PIX_W];
                    state_reg <= F_MUL;
                end
                F_MUL: begin
                    prod_x_reg <= PROD_W'(m_x) * PROD_W'($signed({1'b0, cfg_i.zoom}));
                    prod_y_reg <= PROD_W'(m_y) * PROD_W'($signed({1'b0, cfg_i.zoom}));
                    state_reg  <= F_ADD;
                end
                F_ADD: begin
                    coord_x_reg <= etf_pkg::sat_fix(PROD_W'(t_x) + PROD_W'(cfg_i.offset_re));
                    coord_y_reg <= etf_pkg::sat_fix(PROD_W'(t_y) + PROD_W'(cfg_i.offset_im));
                    state_reg   <= F_PUSH;
                end
                F_PUSH: begin
                    if (!full_i) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign push_o  = (state_reg == F_PUSH) && !full_i;

    always_comb begin
        job_o.kind = kind_reg;
        job_o.px   = px_reg;
        job_o.py   = py_reg;
        if (kind_reg == etf_pkg::KIND_JULIA) begin
            job_o.zr = coord_x_reg;
            job_o.zi = coord_y_reg;
            job_o.cr = cfg_i.julia_re;
            job_o.ci = cfg_i.julia_im;
        end else begin
            job_o.zr = '0;
            job_o.zi = '0;
            job_o.cr = coord_x_reg;
            job_o.ci = coord_y_reg;
        end
    end

    `ETF_ASSERT_NEXT(a_front_accept_divides, aclk, aresetn, s_valid && s_ready,
        state_reg == F_DIV, "accepted pixel did not start the division")

endmodule

[rtl/etf_queue.sv]
`include "escape_time_fractal_unit_macros.svh"

module etf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_i,
    input  etf_pkg::job_t  job_i,
    output logic           full_o,
    input  logic           pop_i,
    output etf_pkg::job_t  job_o,
    output logic           empty_o
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    etf_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= job_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_i && !pop_i) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_i && !push_i) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign full_o  = (count_reg == CNT_W'(DEPTH));
    assign empty_o = (count_reg == '0);
    assign job_o   = entry_reg[rd_ptr_reg];

    `ETF_ASSERT(a_queue_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "queue holds more entries than its depth")
    `ETF_ASSERT_NEXT(a_queue_fill, aclk, aresetn, push_i && !pop_i && !full_o, count_reg == $past(count_reg) + 1'b1, "push did not add a queue entry")

endmodule

[rtl/etf_iter.sv]
`include "escape_time_fractal_unit_macros.svh"

module etf_iter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  etf_pkg::cfg_t                      cfg_i,
    input  logic                               empty_i,
    output logic                               pop_o,
    input  etf_pkg::job_t                      job_i,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [etf_pkg::PIX_W-1:0]          m_out_x,
    output logic [etf_pkg::PIX_W-1:0]          m_out_y,
    output logic [etf_pkg::ITER_W-1:0]         m_iterations,
    output logic signed [etf_pkg::FIX_W-1:0]   m_final_re,
    output logic signed [etf_pkg::FIX_W-1:0]   m_final_im
);

    localparam int PIX_W  = etf_pkg::PIX_W;
    localparam int ITER_W = etf_pkg::ITER_W;
    localparam int FIX_W  = etf_pkg::FIX_W;
    localparam int PROD_W = etf_pkg::PROD_W;
    localparam int WIDE_W = etf_pkg::WIDE_W;

    localparam logic signed [WIDE_W-1:0] FOUR_W = WIDE_W'(etf_pkg::FOUR);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_STEP,
        B_DONE
    } bstate_t;

    bstate_t                   state_reg;
    etf_pkg::kind_t            kind_reg;
    logic [PIX_W-1:0]          px_reg;
    logic [PIX_W-1:0]          py_reg;
    logic signed [FIX_W-1:0]   x_reg;
    logic signed [FIX_W-1:0]   y_reg;
    logic signed [FIX_W-1:0]   cr_reg;
    logic signed [FIX_W-1:0]   ci_reg;
    logic [ITER_W-1:0]         it_reg;
    logic signed [PROD_W-1:0]  xx_reg;
    logic signed [PROD_W-1:0]  yy_reg;
    logic signed [PROD_W-1:0]  xy_reg;
    logic                      m_valid_reg;
    logic [PIX_W-1:0]          out_x_reg;
    logic [PIX_W-1:0]          out_y_reg;
    logic [ITER_W-1:0]         iter_out_reg;
    logic signed [FIX_W-1:0]   re_out_reg;
    logic signed [FIX_W-1:0]   im_out_reg;

    logic signed [PROD_W-1:0]  xx_sh;
    logic signed [PROD_W-1:0]  yy_sh;
    logic signed [PROD_W-1:0]  xy_sh;
    logic signed [WIDE_W-1:0]  x2;
    logic signed [WIDE_W-1:0]  y2;
    logic signed [WIDE_W-1:0]  xy;
    logic signed [WIDE_W-1:0]  mag;
    logic signed [WIDE_W-1:0]  nx;
    logic signed [WIDE_W-1:0]  ny;
    logic signed [WIDE_W-1:0]  nx_fix;
    logic signed [WIDE_W-1:0]  ny_fix;
    logic                      escape;
    logic signed [FIX_W-1:0]   x_next;
    logic signed [FIX_W-1:0]   y_next;
    logic                      load_out;

    always_comb begin
        xx_sh = xx_reg >>> etf_pkg::FRAC_BITS;
        yy_sh = yy_reg >>> etf_pkg::FRAC_BITS;
        xy_sh = xy_reg >>> etf_pkg::FRAC_BITS;
        x2    = xx_sh[WIDE_W-1:0];
        y2    = yy_sh[WIDE_W-1:0];
        xy    = xy_sh[WIDE_W-1:0];
        mag   = x2 + y2;
        // Mandelbrot escapes strictly above 4; the other kinds at 4 already.
        if (kind_reg == etf_pkg::KIND_MANDEL) begin
            escape = (mag > FOUR_W);
        end else begin
            escape = (mag >= FOUR_W);
        end
        nx = x2 - y2 + WIDE_W'(cr_reg);
        ny = (xy <<< 1) + WIDE_W'(ci_reg);
        if (kind_reg == etf_pkg::KIND_SHIP) begin
            nx_fix = (nx < 0) ? -nx : nx;
            ny_fix = (ny < 0) ? -ny : ny;
        end else begin
            nx_fix = nx;
            ny_fix = ny;
        end
        x_next = etf_pkg::sat_fix(PROD_W'(nx_fix));
        y_next = etf_pkg::sat_fix(PROD_W'(ny_fix));
    end

    assign pop_o    = (state_reg == B_IDLE) && !empty_i;
    assign load_out = (state_reg == B_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!empty_i) begin
                        kind_reg  <= job_i.kind;
                        px_reg    <= job_i.px;
                        py_reg    <= job_i.py;
                        x_reg     <= job_i.zr;
                        y_reg     <= job_i.zi;
                        cr_reg    <= job_i.cr;
                        ci_reg    <= job_i.ci;
                        it_reg    <= '0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: begin
                    if (it_reg == cfg_i.iter_limit) begin
                        state_reg <= B_DONE;
                    end else begin
                        xx_reg    <= x_reg * x_reg;
                        yy_reg    <= y_reg * y_reg;
                        xy_reg    <= x_reg * y_reg;
                        state_reg <= B_STEP;
                    end
                end
                B_STEP: begin
                    if (escape) begin
                        state_reg <= B_DONE;
                    end else begin
                        x_reg     <= x_next;
                        y_reg     <= y_next;
                        it_reg    <= it_reg + 1'b1;
                        state_reg <= B_MUL;
                    end
                end
                B_DONE: begin
                    if (load_out) begin
                        out_x_reg    <= px_reg;
                        out_y_reg    <= py_reg;
                        iter_out_reg <= it_reg;
                        re_out_reg   <= x_reg;
                        im_out_reg   <= y_reg;
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_x      = out_x_reg;
    assign m_out_y      = out_y_reg;
    assign m_iterations = iter_out_reg;
    assign m_final_re   = re_out_reg;
    assign m_final_im   = im_out_reg;

    `ETF_ASSERT_NEXT(a_iter_count_step, aclk, aresetn, state_reg == B_STEP && !escape,
        it_reg == $past(it_reg) + 1'b1, "iteration count did not advance on a completed step")

endmodule

[rtl/escape_time_fractal_unit.sv]
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | s_pixel_x, s_pixel_y
// m_        | out       | m_valid / m_ready  | m_out_x, m_out_y, m_iterations,
//           |           |                    | m_final_re, m_final_im
// cfg_      | in        | cfg_wen            | cfg_addr, cfg_wdata
//
// The front end maps one pixel through states for accept, the division of the
// remainder term by the frame size through a reciprocal multiply, the zoom
// multiply, the center add and the push into the queue.
// Each escape-time step of the iteration engine has one state for the three
// products and one for sum, test and saturation; a pixel occupies the engine
// until it escapes or reaches the limit and its result is loaded for output.
// A two-entry queue between the two lets the front end map the next pixel
// while the engine iterates and while a result waits on m_ready.
// Reset is synchronous on aresetn low and restores the configuration defaults.

module escape_time_fractal_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [etf_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [etf_pkg::FIX_W-1:0]              cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [etf_pkg::PIX_W-1:0]              s_pixel_x,
    input  logic [etf_pkg::PIX_W-1:0]              s_pixel_y,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [etf_pkg::PIX_W-1:0]              m_out_x,
    output logic [etf_pkg::PIX_W-1:0]              m_out_y,
    output logic [etf_pkg::ITER_W-1:0]             m_iterations,
    output logic signed [etf_pkg::FIX_W-1:0]       m_final_re,
    output logic signed [etf_pkg::FIX_W-1:0]       m_final_im
);

    etf_pkg::cfg_t  cfg_reg;
    etf_pkg::job_t  push_job;
    etf_pkg::job_t  pop_job;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= etf_pkg::MODE_MANDEL;
            cfg_reg.iter_limit <= etf_pkg::ITER_LIMIT_RESET;
            cfg_reg.zoom       <= etf_pkg::ZOOM_RESET;
            cfg_reg.offset_re  <= '0;
            cfg_reg.offset_im  <= '0;
            cfg_reg.julia_re   <= '0;
            cfg_reg.julia_im   <= '0;
        end else if (cfg_wen) begin
            case (etf_pkg::cfg_index_t'(cfg_addr))
                etf_pkg::CFG_MODE: begin
                    cfg_reg.mode <= cfg_wdata[etf_pkg::MODE_W-1:0];
                end
                etf_pkg::CFG_ITER_LIMIT: begin
                    cfg_reg.iter_limit <= cfg_wdata[etf_pkg::ITER_W-1:0];
                end
                etf_pkg::CFG_ZOOM: begin
                    cfg_reg.zoom <= cfg_wdata[etf_pkg::ZOOM_W-1:0];
                end
                etf_pkg::CFG_OFFSET_RE: begin
                    cfg_reg.offset_re <= cfg_wdata;
                end
                etf_pkg::CFG_OFFSET_IM: begin
                    cfg_reg.offset_im <= cfg_wdata;
                end
                etf_pkg::CFG_JULIA_RE: begin
                    cfg_reg.julia_re <= cfg_wdata;
                end
                etf_pkg::CFG_JULIA_IM: begin
                    cfg_reg.julia_im <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    etf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_i     (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel_x (s_pixel_x),
        .s_pixel_y (s_pixel_y),
        .full_i    (q_full),
        .push_o    (push),
        .job_o     (push_job)
    );

    etf_queue #(
        .DEPTH (2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .job_i   (push_job),
        .full_o  (q_full),
        .pop_i   (pop),
        .job_o   (pop_job),
        .empty_o (q_empty)
    );

    etf_iter u_iter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg_reg),
        .empty_i      (q_empty),
        .pop_o        (pop),
        .job_i        (pop_job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_iterations (m_iterations),
        .m_final_re   (m_final_re),
        .m_final_im   (m_final_im)
    );

endmodule
